// ----- rtl/pfa_pkg.sv -----
package pfa_pkg;

   // pool geometry
   localparam int MaxFrames = 256;
   localparam int FrameWidth = $clog2(MaxFrames);
   localparam int CountWidth = FrameWidth + 1;

   typedef logic [FrameWidth-1:0] frame_type;
   typedef logic [CountWidth-1:0] count_type;

   // num_frames register reset value
   localparam count_type NumFramesReset = CountWidth'(MaxFrames);

   // operation codes carried in the request tuser
   typedef enum logic [1:0] {
      FUNC_ALLOC   = 2'd0,
      FUNC_RELEASE = 2'd1,
      FUNC_FORMAT  = 2'd2,
      FUNC_NOP     = 2'd3
   } func_type;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_NOT_ALLOC = 2'd2,
      ST_ZERO      = 2'd3
   } status_type;

   // recycle stack control
   typedef struct packed {
      logic      push;
      logic      pop;
      logic      clear;
      frame_type data;
   } stack_ctl_type;

   // in-use map control
   typedef struct packed {
      logic      set;
      logic      clr;
      logic      wipe;
      frame_type frame;
   } map_ctl_type;

   // format size clipped to the pool capacity
   function automatic count_type clip_pool(input count_type n);
      clip_pool = (n > CountWidth'(MaxFrames)) ? CountWidth'(MaxFrames) : n;
   endfunction

endpackage

// ----- rtl/pfa_ram.sv -----
module pfa_ram #(
   parameter int Width = 8,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // one write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/pfa_stack.sv -----
module pfa_stack
   import pfa_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  stack_ctl_type ctl,
   output frame_type     top,
   output logic          empty,
   output logic          full
);

   count_type count_ff, count_in;
   frame_type top_ff, top_in;
   count_type below_idx;
   frame_type rd_addr;
   frame_type rd_data;

   // top entry lives in a register, the entry under it is prefetched from ram
   always_comb begin
      count_in = count_ff;
      top_in   = top_ff;
      if (ctl.clear) begin
         count_in = '0;
      end else if (ctl.push) begin
         count_in = count_ff + CountWidth'(1);
         top_in   = ctl.data;
      end else if (ctl.pop) begin
         count_in = count_ff - CountWidth'(1);
         top_in   = rd_data;
      end
   end

   // read address follows the entry under the next top
   assign below_idx = count_in - CountWidth'(2);
   assign rd_addr   = below_idx[FrameWidth-1:0];

   pfa_ram #(
      .Width (FrameWidth),
      .Depth (MaxFrames)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ctl.push),
      .wr_addr (count_ff[FrameWidth-1:0]),
      .wr_data (ctl.data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // stack depth
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // cached top entry
   always_ff @(posedge clock) begin
      top_ff <= top_in;
   end

   assign top   = top_ff;
   assign empty = (count_ff == '0);
   assign full  = (count_ff == CountWidth'(MaxFrames));

endmodule

// ----- rtl/pfa_map.sv -----
module pfa_map
   import pfa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  map_ctl_type ctl,
   input  frame_type   query,
   output logic        busy
);

   logic [MaxFrames-1:0] in_use_ff, in_use_in;

   // one bit per frame, wiped by format
   always_comb begin
      in_use_in = in_use_ff;
      if (ctl.wipe) begin
         in_use_in = '0;
      end else if (ctl.set) begin
         in_use_in[ctl.frame] = 1'b1;
      end else if (ctl.clr) begin
         in_use_in[ctl.frame] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff <= '0;
      end else begin
         in_use_ff <= in_use_in;
      end
   end

   assign busy = in_use_ff[query];

endmodule

// ----- rtl/physical_frame_allocator.sv -----
// Physical page frame allocator.
// Requests arrive on the req_ stream: req_tuser carries the operation
// (allocate, release, format, no operation) and req_tdata the frame to
// release. Every request gives exactly one response on the rsp_ stream:
// rsp_tuser carries the status and rsp_tdata the allocated frame.
// Allocate returns the most recently released frame first, else the
// lowest frame not yet handed out since the last format.
// The csr_ port writes num_frames, which the next format latches as the
// pool size; write it only while no request is in flight.
// A request is taken into the input register and, once the output side is
// free, moves to the output register that drives rsp_tvalid. One request
// is taken per cycle unless the receiver stalls; the recycle stack keeps
// its top in a register and prefetches the next entry from its ram.
// Reset empties the stack, clears the in-use map, restores a 256-frame
// pool and num_frames to 256; no clearing pass is needed.
// When the receiver stalls, the response holds and the input register
// fills, after which req_tready drops until rsp_tready returns.
module physical_frame_allocator
   import pfa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [FrameWidth-1:0] req_tdata,   // [7:0] frame_in
   input  logic [1:0]            req_tuser,   // [1:0] func
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [FrameWidth-1:0] rsp_tdata,   // [7:0] frame_out
   output logic [1:0]            rsp_tuser,   // [1:0] status
   input  logic                  csr_wr_en,
   input  logic [CountWidth-1:0] csr_wr_data
);

   logic          in_valid_ff, in_valid_in;
   func_type      in_func_ff;
   frame_type     in_frame_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   status_type    rsp_status_ff, rsp_status_in;
   frame_type     rsp_frame_ff, rsp_frame_in;
   count_type     num_frames_ff;
   count_type     pool_limit_ff, pool_limit_in;
   count_type     fresh_ff, fresh_in;
   logic          out_free;
   logic          advance;
   stack_ctl_type stk_ctl;
   map_ctl_type   map_ctl;
   frame_type     stk_top;
   logic          stk_empty;
   logic          stk_full;
   logic          map_busy;

   // handshake between the two register stages
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || advance;

   // input register
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_func_ff  <= func_type'(req_tuser);
         in_frame_ff <= req_tdata;
      end
   end

   // num_frames register
   always_ff @(posedge clock) begin
      if (reset) begin
         num_frames_ff <= NumFramesReset;
      end else if (csr_wr_en) begin
         num_frames_ff <= csr_wr_data;
      end
   end

   // request decode and state update
   always_comb begin
      rsp_status_in = ST_OK;
      rsp_frame_in  = '0;
      pool_limit_in = pool_limit_ff;
      fresh_in      = fresh_ff;
      stk_ctl       = '0;
      map_ctl       = '0;
      if (advance) begin
         case (in_func_ff)
            FUNC_ALLOC: begin
               if (!stk_empty) begin
                  stk_ctl.pop   = 1'b1;
                  rsp_frame_in  = stk_top;
                  map_ctl.set   = 1'b1;
                  map_ctl.frame = stk_top;
               end else if (fresh_ff < pool_limit_ff) begin
                  rsp_frame_in  = fresh_ff[FrameWidth-1:0];
                  map_ctl.set   = 1'b1;
                  map_ctl.frame = fresh_ff[FrameWidth-1:0];
                  fresh_in      = fresh_ff + CountWidth'(1);
               end else begin
                  rsp_status_in = ST_EMPTY;
               end
            end
            FUNC_RELEASE: begin
               if (map_busy) begin
                  map_ctl.clr   = 1'b1;
                  map_ctl.frame = in_frame_ff;
                  stk_ctl.push  = !stk_full;
                  stk_ctl.data  = in_frame_ff;
               end else begin
                  rsp_status_in = ST_NOT_ALLOC;
               end
            end
            FUNC_FORMAT: begin
               if (num_frames_ff == '0) begin
                  rsp_status_in = ST_ZERO;
               end else begin
                  pool_limit_in = clip_pool(num_frames_ff);
                  fresh_in      = '0;
                  stk_ctl.clear = 1'b1;
                  map_ctl.wipe  = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   pfa_stack u_stack (
      .clock (clock),
      .reset (reset),
      .ctl   (stk_ctl),
      .top   (stk_top),
      .empty (stk_empty),
      .full  (stk_full)
   );

   pfa_map u_map (
      .clock (clock),
      .reset (reset),
      .ctl   (map_ctl),
      .query (in_frame_ff),
      .busy  (map_busy)
   );

   // pool bounds
   always_ff @(posedge clock) begin
      if (reset) begin
         pool_limit_ff <= clip_pool(NumFramesReset);
         fresh_ff      <= '0;
      end else begin
         pool_limit_ff <= pool_limit_in;
         fresh_ff      <= fresh_in;
      end
   end

   // result register
   assign rsp_valid_in = out_free ? in_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_status_ff <= rsp_status_in;
         rsp_frame_ff  <= rsp_frame_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_frame_ff;
   assign rsp_tuser  = rsp_status_ff;

   // fresh frame pointer never passes the pool limit
   a_fresh_bound: assert property (@(posedge clock) disable iff (reset)
      fresh_ff <= pool_limit_ff)
      else $error("fresh frame pointer beyond pool limit");

   // an accepted release leaves a frame on the recycle stack
   a_release_push: assert property (@(posedge clock) disable iff (reset)
      (advance && in_func_ff == FUNC_RELEASE && map_busy) |=> !stk_empty)
      else $error("release did not reach the recycle stack");

   // a stalled request holds in the input register
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_free) |=> (in_valid_ff && $stable(in_frame_ff)))
      else $error("input register lost a stalled request");

   // failed requests return frame zero
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_OK) |-> (rsp_frame_ff == '0))
      else $error("nonzero frame on failed request");

endmodule

// ----- verif/physical_frame_allocator_checker.sv -----
module physical_frame_allocator_checker
   import pfa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [FrameWidth-1:0] req_tdata,   // [7:0] frame_in
   input  logic [1:0]            req_tuser,   // [1:0] func
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [FrameWidth-1:0] rsp_tdata,   // [7:0] frame_out
   input  logic [1:0]            rsp_tuser,   // [1:0] status
   input  logic                  csr_wr_en,
   input  logic [CountWidth-1:0] csr_wr_data,
   output int                    mismatches,
   output int                    outstanding
);

   typedef struct packed {
      status_type status;
      frame_type  frame;
   } frame_result_type;

   // expected responses, oldest first
   frame_result_type expected_results[$];

   // shadow allocator state
   frame_type            recycled_frames[$];
   logic [MaxFrames-1:0] frame_busy;
   count_type            fresh_next;
   count_type            pool_size;
   count_type            num_frames_shadow;
   int                   fail_total = 0;

   task automatic report_mismatch(input string what);
      fail_total++;
      if (fail_total <= 100) begin
         $display("mismatch at %0t: %s", $time, what);
      end
   endtask

   // apply one request to the shadow state and return its response
   function automatic frame_result_type serve_request(input func_type op,
                                                      input frame_type frame_in);
      frame_result_type res;
      res.status = ST_OK;
      res.frame  = '0;
      case (op)
         FUNC_ALLOC: begin
            // last released frame first, then the lowest fresh one
            if (recycled_frames.size() != 0) begin
               res.frame = recycled_frames.pop_back();
               frame_busy[res.frame] = 1'b1;
            end else if (fresh_next < pool_size) begin
               res.frame = fresh_next[FrameWidth-1:0];
               frame_busy[res.frame] = 1'b1;
               fresh_next = fresh_next + 1'b1;
            end else begin
               res.status = ST_EMPTY;
            end
         end
         FUNC_RELEASE: begin
            if (frame_busy[frame_in]) begin
               frame_busy[frame_in] = 1'b0;
               recycled_frames.push_back(frame_in);
            end else begin
               res.status = ST_NOT_ALLOC;
            end
         end
         FUNC_FORMAT: begin
            // zero size leaves the pool as it is
            if (num_frames_shadow == '0) begin
               res.status = ST_ZERO;
            end else begin
               pool_size = (num_frames_shadow > count_type'(MaxFrames)) ?
                           count_type'(MaxFrames) : num_frames_shadow;
               fresh_next = '0;
               recycled_frames.delete();
               frame_busy = '0;
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      frame_result_type want;
      if (reset) begin
         num_frames_shadow = NumFramesReset;
         pool_size         = count_type'(MaxFrames);
         fresh_next        = '0;
         frame_busy        = '0;
         recycled_frames.delete();
         expected_results.delete();
      end else begin
         if (csr_wr_en) begin
            num_frames_shadow = csr_wr_data;
         end
         // responses first: one accepted now belongs to an older request
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("response with nothing pending: status %0d frame %0d",
                                         rsp_tuser, rsp_tdata));
            end else begin
               want = expected_results.pop_front();
               if (rsp_tuser !== want.status) begin
                  report_mismatch($sformatf("status %0d, expected %s",
                                            rsp_tuser, want.status.name()));
               end
               if (rsp_tdata !== want.frame) begin
                  report_mismatch($sformatf("frame_out %0d, expected %0d",
                                            rsp_tdata, want.frame));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            expected_results.push_back(serve_request(func_type'(req_tuser), req_tdata));
         end
      end
      mismatches  <= fail_total;
      outstanding <= expected_results.size();
   end

endmodule

// ----- verif/physical_frame_allocator_tb.sv -----
module physical_frame_allocator_tb
   import pfa_pkg::*;
();

   localparam int StallLimit = 5000;
   localparam int HoldCycles = 80;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [FrameWidth-1:0] req_tdata;   // [7:0] frame_in
   logic [1:0]            req_tuser;   // [1:0] func
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [FrameWidth-1:0] rsp_tdata;   // [7:0] frame_out
   logic [1:0]            rsp_tuser;   // [1:0] status
   logic                  csr_wr_en;
   logic [CountWidth-1:0] csr_wr_data;
   int                    mismatches;
   int                    outstanding;

   // idle rates in percent, hold-off trigger, stall counter
   int        send_idle_pct = 15;
   int        recv_idle_pct = 86;
   bit        rsp_hold_go = 1'b0;
   int        stall_cycles = 0;

   // rough view of the pool, only to aim releases at held frames
   count_type cfg_now = NumFramesReset;
   int        pool_now = MaxFrames;
   int        fresh_hint = 0;

   physical_frame_allocator u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   physical_frame_allocator_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // response side: random back-pressure plus one long hold-off
   initial begin
      int  hold_left;
      bit  hold_used;
      hold_left  = 0;
      hold_used  = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_go && !hold_used) begin
            hold_used = 1'b1;
            hold_left = HoldCycles;
         end
         if (hold_left > 0) begin
            rsp_tready = 1'b0;
            hold_left--;
         end else begin
            rsp_tready = ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      wait (stall_cycles >= StallLimit);
      $display("simulation failed");
      $finish;
   end

   // offer one request and hold it until accepted
   task automatic send_request(input func_type op, input frame_type frame_in);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         req_tdata  = frame_type'($urandom_range(255));
         req_tuser  = 2'($urandom_range(3));
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = op;
      req_tdata  = frame_in;
      if (op == FUNC_ALLOC && fresh_hint < pool_now) begin
         fresh_hint++;
      end
      if (op == FUNC_FORMAT && cfg_now != '0) begin
         pool_now   = (cfg_now > MaxFrames) ? MaxFrames : int'(cfg_now);
         fresh_hint = 0;
      end
      do @(posedge clock); while (!req_tready);
   endtask

   // stop offering and wait for every pending response
   task automatic drain_results();
      @(negedge clock);
      req_tvalid = 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_num_frames(input count_type value);
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      cfg_now     = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // mostly allocate and release of held frames, some noise
   task automatic send_random(input int alloc_wt, input int format_pct);
      int        roll;
      frame_type pick;
      roll = $urandom_range(99);
      if (roll < alloc_wt) begin
         send_request(FUNC_ALLOC, frame_type'($urandom_range(255)));
      end else if (roll < 98 - format_pct) begin
         if (fresh_hint > 0 && $urandom_range(9) < 8) begin
            pick = frame_type'($urandom_range(fresh_hint - 1));
         end else begin
            pick = frame_type'($urandom_range(255));
         end
         send_request(FUNC_RELEASE, pick);
      end else if (roll < 98) begin
         send_request(FUNC_FORMAT, frame_type'($urandom_range(255)));
      end else begin
         send_request(FUNC_NOP, frame_type'($urandom_range(255)));
      end
   endtask

   task automatic run_segment(input count_type frames, input int items,
                              input int alloc_wt, input int format_pct);
      drain_results();
      write_num_frames(frames);
      send_request(FUNC_FORMAT, frame_type'($urandom_range(255)));
      repeat (items) send_random(alloc_wt, format_pct);
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = FUNC_NOP;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: pool left by reset
      send_request(FUNC_ALLOC, 8'd0);
      send_request(FUNC_RELEASE, 8'd0);
      send_request(FUNC_RELEASE, 8'd0);
      send_request(FUNC_NOP, 8'd255);

      // directed: four-frame pool, exhaustion, bad releases, lifo reuse
      drain_results();
      write_num_frames(count_type'(4));
      send_request(FUNC_FORMAT, 8'd0);
      repeat (4) send_request(FUNC_ALLOC, 8'd0);
      send_request(FUNC_ALLOC, 8'd255);
      send_request(FUNC_RELEASE, 8'd2);
      send_request(FUNC_RELEASE, 8'd2);
      send_request(FUNC_RELEASE, 8'd200);
      send_request(FUNC_RELEASE, 8'd0);
      send_request(FUNC_ALLOC, 8'd0);
      send_request(FUNC_ALLOC, 8'd0);
      send_request(FUNC_RELEASE, 8'd255);
      send_request(FUNC_RELEASE, 8'd3);

      // directed: zero-frame format keeps the pool
      drain_results();
      write_num_frames(count_type'(0));
      send_request(FUNC_FORMAT, 8'd0);
      send_request(FUNC_ALLOC, 8'd0);

      // directed: oversize format clips to the capacity
      drain_results();
      write_num_frames('1);
      send_request(FUNC_FORMAT, 8'd255);
      send_request(FUNC_ALLOC, 8'd0);
      send_request(FUNC_RELEASE, 8'd255);

      // sender mostly busy, receiver mostly stalled
      run_segment(count_type'(3), 100, 45, 2);
      run_segment(count_type'(MaxFrames), 100, 70, 2);
      run_segment(count_type'($urandom_range(40, 5)), 100, 45, 2);
      run_segment(count_type'(1), 100, 50, 2);

      // sender mostly idle, receiver mostly ready
      send_idle_pct = 86;
      recv_idle_pct = 15;
      run_segment('1, 100, 60, 2);
      run_segment(count_type'(0), 100, 45, 2);
      run_segment(count_type'($urandom_range(64, 2)), 100, 45, 2);
      run_segment(count_type'(8), 100, 50, 2);

      // no idling: exhaust the full pool, then fill up behind a hold-off
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_segment(count_type'(MaxFrames), 330, 88, 0);
      drain_results();
      rsp_hold_go = 1'b1;
      repeat (40) send_random(50, 2);
      run_segment(count_type'($urandom_range(300, 1)), 70, 50, 2);
      run_segment(count_type'(2), 70, 45, 2);
      run_segment(count_type'(40), 70, 50, 2);

      drain_results();
      repeat (4) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ----- physical_frame_allocator.f -----
rtl/pfa_pkg.sv
rtl/pfa_ram.sv
rtl/pfa_stack.sv
rtl/pfa_map.sv
rtl/physical_frame_allocator.sv
verif/physical_frame_allocator_checker.sv
verif/physical_frame_allocator_tb.sv
